// ===== rtl/lfps_pkg.sv =====
// Shared types and constants for the line follower PID steering block.
// Holds the register map, the configuration bundle and the queue word format.
// No dependencies.
package lfps_pkg;

  localparam int REG_W = 16;
  localparam int IDX_W = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_I         = 3'd1,
    REG_GAIN_D         = 3'd2,
    REG_INTEGRAL_LIMIT = 3'd3,
    REG_BASE_VALUE     = 3'd4,
    REG_EDGE_RIGHT     = 3'd5,
    REG_DRIVE_MODE     = 3'd6,
    REG_TARGET_LEVEL   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic        [15:0] gain_p;
    logic        [15:0] gain_i;
    logic        [15:0] gain_d;
    logic signed [15:0] integral_limit;
    logic        [14:0] base_value;
    logic               edge_right;
    logic               drive_mode;
    logic        [15:0] target_level;
  } cfg_t;

  // one classified sample as handed from front to back
  typedef struct packed {
    logic signed [15:0] err;
    logic signed [15:0] sum;
    logic signed [15:0] diff;
  } work_t;

  // floor(m / 1000) == (m * RECIP_1000) >> RECIP_SHIFT, exact for any 32 bit m
  localparam logic [28:0] RECIP_1000  = 29'd274877907;
  localparam int          RECIP_SHIFT = 38;

  localparam logic [15:0] RST_GAIN_P  = 16'd600;
  localparam logic [15:0] RST_GAIN_I  = 16'd0;
  localparam logic [15:0] RST_GAIN_D  = 16'd200;
  localparam logic [15:0] RST_LIMIT   = 16'd100;
  localparam logic [14:0] RST_BASE    = 15'd200;
  localparam logic [15:0] RST_TARGET  = 16'd225;

endpackage

// ===== rtl/lfps_cfg.sv =====
// Configuration register file for the steering block.
// Depends on lfps_pkg.
module lfps_cfg import lfps_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  output cfg_t             cfg,
  output logic             target_wr
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p         <= RST_GAIN_P;
      cfg.gain_i         <= RST_GAIN_I;
      cfg.gain_d         <= RST_GAIN_D;
      cfg.integral_limit <= RST_LIMIT;
      cfg.base_value     <= RST_BASE;
      cfg.edge_right     <= 1'b0;
      cfg.drive_mode     <= 1'b1;
      cfg.target_level   <= RST_TARGET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_GAIN_P:         cfg.gain_p         <= cfg_data;
        REG_GAIN_I:         cfg.gain_i         <= cfg_data;
        REG_GAIN_D:         cfg.gain_d         <= cfg_data;
        REG_INTEGRAL_LIMIT: cfg.integral_limit <= cfg_data;
        REG_BASE_VALUE:     cfg.base_value     <= cfg_data[14:0];
        REG_EDGE_RIGHT:     cfg.edge_right     <= cfg_data[0];
        REG_DRIVE_MODE:     cfg.drive_mode     <= cfg_data[0];
        REG_TARGET_LEVEL:   cfg.target_level   <= cfg_data;
        default: ;
      endcase
    end
  end

  // a fresh target releases the stop latch in the front end
  assign target_wr = cfg_we && (reg_idx_t'(cfg_index) == REG_TARGET_LEVEL);

endmodule

// ===== rtl/lfps_front.sv =====
// Front end: takes sensor words, forms the error, the running sum and the
// derivative difference, and pushes them to the queue. Depends on lfps_pkg.
module lfps_front import lfps_pkg::*; #(
  parameter int SENSOR_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   target_wr,
  input  logic                   in_valid,
  input  logic [SENSOR_BITS-1:0] sensor,
  input  logic                   stop,
  output logic                   in_ready,
  input  logic                   q_full,
  output logic                   push,
  output work_t                  push_item
);

  logic signed [15:0] error_sum;
  logic signed [15:0] previous_error;
  logic               target_cleared;

  logic               cleared_now;
  logic        [15:0] target;
  logic signed [15:0] err;
  logic signed [15:0] error_sum_next;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    cleared_now = target_cleared || stop;
    target      = cleared_now ? 16'd0 : cfg.target_level;
    err         = $signed(target - 16'(sensor));
    // accumulate only below the limit, no lower clamp
    if (error_sum < cfg.integral_limit) error_sum_next = error_sum + err;
    else                                error_sum_next = error_sum;
    push_item.err  = err;
    push_item.sum  = error_sum_next;
    push_item.diff = previous_error - err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
      target_cleared <= 1'b0;
    end else begin
      if (push) begin
        error_sum      <= error_sum_next;
        previous_error <= err;
      end
      if (target_wr)  target_cleared <= 1'b0;
      else if (push)  target_cleared <= cleared_now;
    end
  end

  a_stop_latches: assert property (@(posedge clk) disable iff (rst)
    (push && stop && !target_wr) |=> target_cleared)
    else $error("stop request did not latch the target");

  a_sum_holds_at_limit: assert property (@(posedge clk) disable iff (rst)
    (push && !(error_sum < cfg.integral_limit)) |=> $stable(error_sum))
    else $error("error sum moved while at or above the limit");

endmodule

// ===== rtl/lfps_queue.sv =====
// Two-entry queue between the front end and the arithmetic back end.
// Depends on lfps_pkg.
module lfps_queue import lfps_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output work_t head
);

  work_t      mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("queue written while full");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");

endmodule

// ===== rtl/lfps_back.sv =====
// Back end: scales the three terms by gain/1000 (truncating toward zero),
// sums them into the correction and forms the motor commands. Depends on lfps_pkg.
module lfps_back import lfps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               q_empty,
  input  work_t              q_head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] left_command,
  output logic signed [15:0] right_command,
  output logic               command_is_speed,
  output logic signed [15:0] p_term,
  output logic signed [15:0] i_term,
  output logic signed [15:0] d_term,
  output logic signed [15:0] correction
);

  logic en;

  // stage 1: products, lane 0 = P, 1 = I, 2 = D
  logic               s1_valid;
  logic signed [32:0] prod [3];
  // stage 2: truncated quotient magnitude, low 16 bits, and sign
  logic               s2_valid;
  logic        [15:0] quot [3];
  logic               neg  [3];
  // stage 3: signed terms
  logic               s3_valid;
  logic signed [15:0] term [3];

  logic signed [15:0] vals  [3];
  logic        [15:0] gains [3];
  logic        [31:0] mag   [3];
  logic        [60:0] qfull [3];
  logic signed [15:0] corr_raw;
  logic signed [15:0] corr;

  assign en  = !out_valid || out_ready;
  assign pop = en && !q_empty;

  always_comb begin
    vals[0]  = q_head.err;
    vals[1]  = q_head.sum;
    vals[2]  = q_head.diff;
    gains[0] = cfg.gain_p;
    gains[1] = cfg.gain_i;
    gains[2] = cfg.gain_d;
    for (int k = 0; k < 3; k++) begin
      mag[k]   = prod[k][32] ? 32'(-prod[k]) : prod[k][31:0];
      qfull[k] = mag[k] * RECIP_1000;
    end
    corr_raw = term[0] + term[1] + term[2];
    corr     = cfg.edge_right ? -corr_raw : corr_raw;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        prod[k] <= vals[k] * $signed({1'b0, gains[k]});
        quot[k] <= qfull[k][RECIP_SHIFT+15:RECIP_SHIFT];
        neg[k]  <= prod[k][32];
        term[k] <= neg[k] ? -$signed(quot[k]) : $signed(quot[k]);
      end
      left_command     <= $signed({1'b0, cfg.base_value}) - corr;
      right_command    <= $signed({1'b0, cfg.base_value}) + corr;
      command_is_speed <= cfg.drive_mode;
      p_term           <= term[0];
      i_term           <= term[1];
      d_term           <= term[2];
      correction       <= corr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= !q_empty;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    (en && s3_valid) |=> out_valid)
    else $error("word lost between term stage and output");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(s1_valid) && $stable(s2_valid) && $stable(s3_valid)))
    else $error("pipeline moved while output stalled");

endmodule

// ===== rtl/line_follow_pid_steering.sv =====
// PID steering for a line follower with differential drive. One sensor word
// in gives one command word out; a new word is taken every cycle while the
// output is drained; each word passes from the front end through the queue,
// three arithmetic stages and the output register. The throughput is set by the
// front end, whose error sum and previous error update on each accepted word;
// a two-word queue lets the front keep accepting up to two words while
// the output is stalled. Depends on lfps_pkg and the lfps_* modules.
module line_follow_pid_steering import lfps_pkg::*; #(
  parameter int SENSOR_BITS = 10,
  localparam int IN_W = ((SENSOR_BITS + 1 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // sensor_value, stop_request, zero fill
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [95:0]      m_tdata,   // left_command, right_command, p_term,
                                      // i_term, d_term, correction
  output logic             m_tuser    // command_is_speed
);

  cfg_t  cfg;
  logic  target_wr;
  logic  q_full;
  logic  q_empty;
  logic  push;
  logic  pop;
  work_t push_item;
  work_t q_head;

  logic signed [15:0] left_command;
  logic signed [15:0] right_command;
  logic signed [15:0] p_term;
  logic signed [15:0] i_term;
  logic signed [15:0] d_term;
  logic signed [15:0] correction;

  lfps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .target_wr (target_wr)
  );

  lfps_front #(.SENSOR_BITS(SENSOR_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .target_wr (target_wr),
    .in_valid  (s_tvalid),
    .sensor    (s_tdata[SENSOR_BITS-1:0]),
    .stop      (s_tdata[SENSOR_BITS]),
    .in_ready  (s_tready),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  lfps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  lfps_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .pop              (pop),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .left_command     (left_command),
    .right_command    (right_command),
    .command_is_speed (m_tuser),
    .p_term           (p_term),
    .i_term           (i_term),
    .d_term           (d_term),
    .correction       (correction)
  );

  assign m_tdata = {correction, d_term, i_term, p_term, right_command, left_command};

endmodule
